// File: rtl/core/caliper_profile_edge_peak_macros.svh
// Assertion macros used by the checker of the caliper edge finder.
`ifndef CALIPER_PROFILE_EDGE_PEAK_MACROS_SVH
`define CALIPER_PROFILE_EDGE_PEAK_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CPEP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpep: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define CPEP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpep: next-cycle check failed");

`endif

// File: rtl/core/cpep_pkg.sv
// Shared types and constants of the caliper edge finder.
package cpep_pkg;

    // Result and configuration field widths.
    localparam int INDEX_W     = 10;
    localparam int SUBINDEX_W  = 18;
    localparam int STRENGTH_W  = 16;
    localparam int GRADIENT_W  = 17;
    localparam int THRESHOLD_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Fraction bits of the refined position.
    localparam int FRAC_BITS = 8;

    // Number of jobs that the queue between front and back holds.
    localparam int QUEUE_DEPTH = 4;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_POLARITY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBPIXEL  = 2'd2;

    // Polarity codes.
    localparam logic [1:0] POL_ANY     = 2'd0;
    localparam logic [1:0] POL_RISING  = 2'd1;
    localparam logic [1:0] POL_FALLING = 2'd2;

    typedef struct packed {
        logic [1:0]             polarity;
        logic [THRESHOLD_W-1:0] threshold;
        logic                   subpixel;
    } cfg_t;

    // Control part of a job passed from front to back.
    typedef struct packed {
        logic update;
        logic report;
        logic found;
        logic overflow;
        logic subpixel;
    } job_ctrl_t;

endpackage

// File: rtl/core/cpep_sample_if.sv
// Sample channel: one profile sample per word.
interface cpep_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   sample_valid;
    logic                   last_sample;

    modport source (
        output valid, sample_value, sample_valid, last_sample,
        input  ready
    );
    modport sink (
        input  valid, sample_value, sample_valid, last_sample,
        output ready
    );
endinterface

// File: rtl/core/cpep_result_if.sv
// Result channel: one edge report per word.
interface cpep_result_if ();
    import cpep_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         edge_found;
    logic [INDEX_W-1:0]           edge_index;
    logic [SUBINDEX_W-1:0]        edge_subindex;
    logic [STRENGTH_W-1:0]        edge_strength;
    logic signed [GRADIENT_W-1:0] edge_gradient;
    logic                         profile_overflow;

    modport source (
        output valid, edge_found, edge_index, edge_subindex, edge_strength,
               edge_gradient, profile_overflow,
        input  ready
    );
    modport sink (
        input  valid, edge_found, edge_index, edge_subindex, edge_strength,
               edge_gradient, profile_overflow,
        output ready
    );
endinterface

// File: rtl/core/cpep_cfg_if.sv
// Configuration write channel: register index and write data per word.
interface cpep_cfg_if ();
    import cpep_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/core/cpep_queue.sv
// Small job queue between the front and the back of the edge finder.
module cpep_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/cpep_front.sv
// Front of the edge finder: gradient, score, peak detection and best tracking.
module cpep_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    cpep_sample_if.sink                            sample_ch,
    input  cpep_pkg::cfg_t                         cfg,
    input  logic                                   queue_full,
    output logic                                   job_push,
    output cpep_pkg::job_ctrl_t                    job_ctrl,
    output logic [SAMPLE_BITS-1:0]                 job_a,
    output logic [SAMPLE_BITS-1:0]                 job_b,
    output logic [SAMPLE_BITS-1:0]                 job_c,
    output logic [$clog2(MAX_SAMPLES + 1)-1:0]     job_index,
    output logic signed [SAMPLE_BITS:0]            job_gradient
);
    import cpep_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int GW = SAMPLE_BITS + 1;

    // Profile control state.
    logic [CW-1:0]          count_reg, count_next;
    logic                   found_reg, found_next;
    logic [SAMPLE_BITS-1:0] best_reg, best_next;
    logic                   ovf_reg, ovf_next;

    // Sliding windows; refilled before use after every profile start.
    logic [SAMPLE_BITS-1:0] value0_reg, value1_reg;
    logic                   vld0_reg, vld1_reg;
    logic [SAMPLE_BITS-1:0] score0_reg, score1_reg;
    logic signed [GW-1:0]   grad1_reg;

    logic                   accept;
    logic                   saturated;
    logic                   feed;
    logic signed [GW-1:0]   grad;
    logic signed [GW-1:0]   grad_mag;
    logic                   grad_neg;
    logic                   pol_ok;
    logic [SAMPLE_BITS-1:0] score;
    logic                   above_thr;
    logic                   is_peak;
    logic                   update;

    assign sample_ch.ready = !queue_full;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign saturated       = (count_reg == CW'(MAX_SAMPLES));
    assign feed            = !saturated;

    // Central difference, zero when a neighbour is missing or at the profile start.
    always_comb
    begin
        grad = '0;
        if ((count_reg >= CW'(2)) && vld0_reg && sample_ch.sample_valid)
        begin
            grad = $signed({1'b0, sample_ch.sample_value}) - $signed({1'b0, value0_reg});
        end
        grad_neg = grad[GW-1];
        grad_mag = grad_neg ? -grad : grad;
    end

    // Score by polarity; code three behaves as any edge.
    always_comb
    begin
        unique case (cfg.polarity)
            POL_RISING:  pol_ok = !grad_neg && (grad != '0);
            POL_FALLING: pol_ok = grad_neg;
            default:     pol_ok = 1'b1;
        endcase
        score = pol_ok ? grad_mag[SAMPLE_BITS-1:0] : '0;
    end

    // Peak test on the middle score of the window.
    always_comb
    begin
        above_thr = {{THRESHOLD_W{1'b0}}, score1_reg} >= {{SAMPLE_BITS{1'b0}}, cfg.threshold};
        is_peak   = (count_reg >= CW'(4)) && above_thr
                    && (score1_reg >= score0_reg) && (score1_reg >= score);
        update    = feed && is_peak && (!found_reg || (score1_reg > best_reg));
    end

    // Job towards the back: a best-peak update, an end-of-profile report, or both.
    always_comb
    begin
        job_push          = accept && (update || sample_ch.last_sample);
        job_ctrl.update   = update;
        job_ctrl.report   = sample_ch.last_sample;
        job_ctrl.found    = found_reg || update;
        job_ctrl.overflow = ovf_reg || saturated;
        job_ctrl.subpixel = cfg.subpixel;
        job_a             = score0_reg;
        job_b             = score1_reg;
        job_c             = score;
        job_index         = count_reg - CW'(2);
        job_gradient      = grad1_reg;
    end

    // Profile control update.
    always_comb
    begin
        count_next = count_reg;
        found_next = found_reg;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (sample_ch.last_sample)
            begin
                count_next = '0;
                found_next = 1'b0;
                best_next  = '0;
                ovf_next   = 1'b0;
            end
            else if (saturated)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (update)
                begin
                    found_next = 1'b1;
                    best_next  = score1_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
            vld0_reg  <= 1'b0;
            vld1_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
            best_reg  <= best_next;
            ovf_reg   <= ovf_next;
            if (accept && feed)
            begin
                vld0_reg <= vld1_reg;
                vld1_reg <= sample_ch.sample_valid;
            end
        end
    end

    // Window shift on every sample taken into detection.
    always_ff @(posedge clk)
    begin
        if (accept && feed)
        begin
            value0_reg <= value1_reg;
            value1_reg <= sample_ch.sample_value;
            score0_reg <= score1_reg;
            score1_reg <= score;
            grad1_reg  <= grad;
        end
    end

endmodule

// File: rtl/core/cpep_back.sv
// Back of the edge finder: sub-sample refinement divider, best peak and result register.
module cpep_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    input  cpep_pkg::job_ctrl_t                job_ctrl,
    input  logic [SAMPLE_BITS-1:0]             job_a,
    input  logic [SAMPLE_BITS-1:0]             job_b,
    input  logic [SAMPLE_BITS-1:0]             job_c,
    input  logic [$clog2(MAX_SAMPLES + 1)-1:0] job_index,
    input  logic signed [SAMPLE_BITS:0]        job_gradient,
    output logic                               job_pop,
    cpep_result_if.source                      result_ch
);
    import cpep_pkg::*;

    localparam int CW        = $clog2(MAX_SAMPLES + 1);
    localparam int GW        = SAMPLE_BITS + 1;
    localparam int NUM_SHIFT = FRAC_BITS - 1;
    localparam int NW        = SAMPLE_BITS + NUM_SHIFT;
    localparam int DW        = SAMPLE_BITS + 1 + NUM_SHIFT;
    localparam int STEP_W    = $clog2(FRAC_BITS);
    localparam int DELTA_W   = FRAC_BITS + 2;
    localparam int SUBW      = (CW + FRAC_BITS + 2 > SUBINDEX_W) ? CW + FRAC_BITS + 2 : SUBINDEX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    job_ctrl_t              ctrl_reg, ctrl_next;
    logic [SAMPLE_BITS-1:0] strength_reg, strength_next;
    logic [CW-1:0]          index_reg, index_next;
    logic signed [GW-1:0]   grad_reg, grad_next;
    logic                   neg_reg, neg_next;
    logic [NW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [FRAC_BITS-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic [INDEX_W-1:0]           best_index_reg;
    logic [SUBINDEX_W-1:0]        best_sub_reg;
    logic [STRENGTH_W-1:0]        best_strength_reg;
    logic signed [GRADIENT_W-1:0] best_grad_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_found_reg;
    logic [INDEX_W-1:0]           out_index_reg;
    logic [SUBINDEX_W-1:0]        out_sub_reg;
    logic [STRENGTH_W-1:0]        out_strength_reg;
    logic signed [GRADIENT_W-1:0] out_grad_reg;
    logic                         out_ovf_reg;

    // Load-time operands of the refinement.
    logic                         ac_neg;
    logic [SAMPLE_BITS-1:0]       ac_mag;
    logic [SAMPLE_BITS+1:0]       den_full;
    logic [SAMPLE_BITS:0]         den_mag;

    // Divider step.
    logic                         div_ge;

    // Fresh best values formed from the finished job.
    logic signed [DELTA_W-1:0]    delta;
    logic [SUBW-1:0]              sub_full;
    logic [CW+INDEX_W-1:0]        index_ext;
    logic [SAMPLE_BITS+STRENGTH_W-1:0] strength_ext;
    logic [GW+GRADIENT_W-1:0]     grad_ext;
    logic [INDEX_W-1:0]           sel_index;
    logic [SUBINDEX_W-1:0]        sel_sub;
    logic [STRENGTH_W-1:0]        sel_strength;
    logic signed [GRADIENT_W-1:0] sel_grad;

    logic                         slot_free;
    logic                         write_best;
    logic                         load_out;

    // With b at least a and c, |a - c| never exceeds |a - 2b + c|, so the
    // quotient stays within 128 and the clamp to one sample never applies.
    always_comb
    begin
        ac_neg   = job_a > job_c;
        ac_mag   = ac_neg ? (job_a - job_c) : (job_c - job_a);
        den_full = ({2'b00, job_b} << 1) - {2'b00, job_a} - {2'b00, job_c};
        den_mag  = den_full[SAMPLE_BITS:0];
    end

    assign div_ge = {1'b0, rem_reg} >= den_reg;

    // Offset sign is opposite to that of a - c, since the denominator is never positive.
    always_comb
    begin
        delta        = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        sub_full     = ({{(SUBW - CW){1'b0}}, index_reg} << FRAC_BITS)
                       + {{(SUBW - DELTA_W){delta[DELTA_W-1]}}, delta};
        index_ext    = {{INDEX_W{1'b0}}, index_reg};
        strength_ext = {{STRENGTH_W{1'b0}}, strength_reg};
        grad_ext     = {{GRADIENT_W{grad_reg[GW-1]}}, grad_reg};
    end

    // Result takes the fresh values when this job also updates the best peak.
    always_comb
    begin
        if (ctrl_reg.update)
        begin
            sel_index    = index_ext[INDEX_W-1:0];
            sel_sub      = sub_full[SUBINDEX_W-1:0];
            sel_strength = strength_ext[STRENGTH_W-1:0];
            sel_grad     = grad_ext[GRADIENT_W-1:0];
        end
        else
        begin
            sel_index    = best_index_reg;
            sel_sub      = best_sub_reg;
            sel_strength = best_strength_reg;
            sel_grad     = best_grad_reg;
        end
    end

    assign slot_free = !out_valid_reg || result_ch.ready;

    // Job sequencer.
    always_comb
    begin
        state_next    = state_reg;
        ctrl_next     = ctrl_reg;
        strength_next = strength_reg;
        index_next    = index_reg;
        grad_next     = grad_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        job_pop       = 1'b0;
        write_best    = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop       = 1'b1;
                    ctrl_next     = job_ctrl;
                    strength_next = job_b;
                    index_next    = job_index;
                    grad_next     = job_gradient;
                    neg_next      = ac_neg;
                    rem_next      = {ac_mag, {NUM_SHIFT{1'b0}}};
                    den_next      = {den_mag, {NUM_SHIFT{1'b0}}};
                    quo_next      = '0;
                    step_next     = STEP_W'(FRAC_BITS - 1);
                    if (job_ctrl.update && job_ctrl.subpixel && (den_mag != '0))
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, restoring.
                if (div_ge)
                begin
                    rem_next = rem_reg - den_reg[NW-1:0];
                end
                den_next = den_reg >> 1;
                quo_next = {quo_reg[FRAC_BITS-2:0], div_ge};
                if (step_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                write_best = ctrl_reg.update;
                if (!ctrl_reg.report)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: holds the word until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job operands and divider.
    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_next;
        strength_reg <= strength_next;
        index_reg    <= index_next;
        grad_reg     <= grad_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
    end

    // Best peak of the current profile; only read when a peak was found.
    always_ff @(posedge clk)
    begin
        if (write_best)
        begin
            best_index_reg    <= index_ext[INDEX_W-1:0];
            best_sub_reg      <= sub_full[SUBINDEX_W-1:0];
            best_strength_reg <= strength_ext[STRENGTH_W-1:0];
            best_grad_reg     <= grad_ext[GRADIENT_W-1:0];
        end
    end

    // Result payload; all peak fields read zero when no peak qualified.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_found_reg    <= ctrl_reg.found;
            out_index_reg    <= ctrl_reg.found ? sel_index : '0;
            out_sub_reg      <= ctrl_reg.found ? sel_sub : '0;
            out_strength_reg <= ctrl_reg.found ? sel_strength : '0;
            out_grad_reg     <= ctrl_reg.found ? sel_grad : '0;
            out_ovf_reg      <= ctrl_reg.overflow;
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.edge_found       = out_found_reg;
    assign result_ch.edge_index       = out_index_reg;
    assign result_ch.edge_subindex    = out_sub_reg;
    assign result_ch.edge_strength    = out_strength_reg;
    assign result_ch.edge_gradient    = out_grad_reg;
    assign result_ch.profile_overflow = out_ovf_reg;

endmodule

// File: rtl/core/caliper_profile_edge_peak.sv
// Caliper edge finder: one sample per cycle while the job queue has room.
// A profile's result goes through the job queue, the back and the output register.
// Only best-peak updates with refinement use the back divider; one job at a time.
// The front stalls only when the 4-entry job queue between front and back is full.
// Reset clears the profile state, the queue and the output register; registers return to
// polarity any, threshold zero and refinement on.
module caliper_profile_edge_peak #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    cpep_sample_if.sink   sample_ch,
    cpep_result_if.source result_ch,
    cpep_cfg_if.sink      cfg_ch
);
    import cpep_pkg::*;

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int GW    = SAMPLE_BITS + 1;
    localparam int JOB_W = $bits(job_ctrl_t) + 3 * SAMPLE_BITS + CW + GW;

    cfg_t                   cfg_reg;

    logic                   f_push;
    job_ctrl_t              f_ctrl;
    logic [SAMPLE_BITS-1:0] f_a, f_b, f_c;
    logic [CW-1:0]          f_index;
    logic signed [GW-1:0]   f_gradient;

    logic [JOB_W-1:0]       push_word;
    logic [JOB_W-1:0]       pop_word;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;

    job_ctrl_t              b_ctrl;
    logic [SAMPLE_BITS-1:0] b_a, b_b, b_c;
    logic [CW-1:0]          b_index;
    logic signed [GW-1:0]   b_gradient;

    // Configuration registers; writes are always taken.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polarity  <= POL_ANY;
            cfg_reg.threshold <= '0;
            cfg_reg.subpixel  <= 1'b1;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_POLARITY:  cfg_reg.polarity  <= cfg_ch.data[1:0];
                REG_THRESHOLD: cfg_reg.threshold <= cfg_ch.data[THRESHOLD_W-1:0];
                REG_SUBPIXEL:  cfg_reg.subpixel  <= cfg_ch.data[0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    cpep_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_ch    (sample_ch),
        .cfg          (cfg_reg),
        .queue_full   (q_full),
        .job_push     (f_push),
        .job_ctrl     (f_ctrl),
        .job_a        (f_a),
        .job_b        (f_b),
        .job_c        (f_c),
        .job_index    (f_index),
        .job_gradient (f_gradient)
    );

    assign push_word = {f_ctrl, f_a, f_b, f_c, f_index, f_gradient};

    cpep_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (push_word),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_ctrl, b_a, b_b, b_c, b_index, b_gradient} = pop_word;

    cpep_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!q_empty),
        .job_ctrl     (b_ctrl),
        .job_a        (b_a),
        .job_b        (b_b),
        .job_c        (b_c),
        .job_index    (b_index),
        .job_gradient (b_gradient),
        .job_pop      (q_pop),
        .result_ch    (result_ch)
    );

endmodule

// File: rtl/core/cpep_checker.sv
// Port-level checks of the caliper edge finder, bound to the top level.
`include "caliper_profile_edge_peak_macros.svh"

module cpep_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   result_valid,
    input logic                                   result_ready,
    input logic                                   edge_found,
    input logic [cpep_pkg::INDEX_W-1:0]           edge_index,
    input logic [cpep_pkg::SUBINDEX_W-1:0]        edge_subindex,
    input logic [cpep_pkg::STRENGTH_W-1:0]        edge_strength,
    input logic signed [cpep_pkg::GRADIENT_W-1:0] edge_gradient,
    input logic                                   profile_overflow
);
    import cpep_pkg::*;

    // No result word straight after reset is released.
    `CPEP_ASSERT_IMP(a_quiet_after_reset, !$past(rst_n), !result_valid)

    // A report without an edge carries zero peak fields.
    `CPEP_ASSERT_IMP(a_no_edge_zero, result_valid && !edge_found, edge_index == '0 && edge_subindex == '0 && edge_strength == '0 && edge_gradient == '0)

    // A word that waits keeps its contents.
    `CPEP_ASSERT_NXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(edge_found) && $stable(edge_index) && $stable(edge_subindex) && $stable(edge_strength) && $stable(edge_gradient) && $stable(profile_overflow))

endmodule

bind caliper_profile_edge_peak cpep_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_ch.valid),
    .result_ready     (result_ch.ready),
    .edge_found       (result_ch.edge_found),
    .edge_index       (result_ch.edge_index),
    .edge_subindex    (result_ch.edge_subindex),
    .edge_strength    (result_ch.edge_strength),
    .edge_gradient    (result_ch.edge_gradient),
    .profile_overflow (result_ch.profile_overflow)
);

// File: verif/caliper_profile_edge_peak_tb.sv
// Self-checking testbench of the caliper edge finder: directed and random profiles.
`timescale 1ns / 1ps

module caliper_profile_edge_peak_tb;
    import cpep_pkg::*;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 8;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // One sample word as offered to the block.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   ok;
        logic                   last;
    } profile_sample_t;

    // One edge report as the block should return it.
    typedef struct packed {
        logic                         found;
        logic [INDEX_W-1:0]           idx;
        logic [SUBINDEX_W-1:0]        sub;
        logic [STRENGTH_W-1:0]        str;
        logic signed [GRADIENT_W-1:0] grad;
        logic                         ovf;
    } edge_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side drive variables, known from time zero.
    profile_sample_t        tx_word   = '0;
    logic                   tx_valid  = 1'b0;
    int unsigned            tx_gap    = 0;
    logic                   rx_ready  = 1'b0;
    int unsigned            rx_wait   = 0;
    logic                   rx_hold   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Idling modes and the trigger of the long receiver hold-off.
    logic tx_idle = 1'b0;
    logic rx_idle = 1'b0;
    logic hold_go = 1'b0;

    profile_sample_t sample_backlog[$];
    edge_report_t    pending_reports[$];
    int              mismatch_count = 0;

    // Local copy of the registers.
    logic [1:0]             want_pol = POL_ANY;
    logic [THRESHOLD_W-1:0] want_thr = '0;
    logic                   want_sub = 1'b1;

    // Local copy of the profile state.
    logic [SAMPLE_BITS-1:0]       hist_val   [2];
    logic                         hist_ok    [2];
    logic [STRENGTH_W-1:0]        hist_score [2];
    logic signed [GRADIENT_W-1:0] hist_grad  [2];
    logic [10:0]                  prof_count;
    logic                         best_hit;
    logic [STRENGTH_W-1:0]        best_str;
    logic [INDEX_W-1:0]           best_idx;
    logic [SUBINDEX_W-1:0]        best_sub;
    logic signed [GRADIENT_W-1:0] best_grad;
    logic                         prof_overflow;

    cpep_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
    cpep_result_if res ();
    cpep_cfg_if    cfg ();

    assign smp.valid        = tx_valid;
    assign smp.sample_value = tx_word.value;
    assign smp.sample_valid = tx_word.ok;
    assign smp.last_sample  = tx_word.last;
    assign res.ready        = rx_ready;
    assign cfg.valid        = cfg_valid;
    assign cfg.index        = cfg_index;
    assign cfg.data         = cfg_data;

    caliper_profile_edge_peak #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(smp),
        .result_ch(res),
        .cfg_ch   (cfg)
    );

    always #5 clk = ~clk;

    // Return the profile state to its empty form.
    function automatic void clear_profile();
        for (int k = 0; k < 2; k++)
        begin
            hist_val[k]   = '0;
            hist_ok[k]    = 1'b0;
            hist_score[k] = '0;
            hist_grad[k]  = '0;
        end
        prof_count    = '0;
        best_hit      = 1'b0;
        best_str      = '0;
        best_idx      = '0;
        best_sub      = '0;
        best_grad     = '0;
        prof_overflow = 1'b0;
    endfunction

    // Score of a gradient under the current polarity; code three behaves as any.
    function automatic int edge_score(int g);
        if (want_pol == POL_RISING && !(g > 0))
            return 0;
        if (want_pol == POL_FALLING && !(g < 0))
            return 0;
        return (g < 0) ? -g : g;
    endfunction

    // Parabolic offset in 1/256 of a sample, truncated and clamped to one sample.
    function automatic int parabola_offset(int a, int b, int c);
        int d;
        int q;
        d = a - 2 * b + c;
        if (d == 0)
            return 0;
        q = (128 * (a - c)) / d;
        if (q > 256)
            q = 256;
        if (q < -256)
            q = -256;
        return q;
    endfunction

    // Advance the gradient and peak search by one in-range sample.
    function automatic void track_sample(logic [SAMPLE_BITS-1:0] v, logic ok);
        int i;
        int g;
        int s;
        int a;
        int b;
        int thr;
        int offs;
        int j;
        i   = prof_count;
        g   = 0;
        s   = 0;
        thr = want_thr;
        if (i >= 2)
        begin
            if (hist_ok[0] && ok)
                g = int'(v) - int'(hist_val[0]);
            s = edge_score(g);
        end
        if (i >= 4)
        begin
            a = hist_score[0];
            b = hist_score[1];
            j = i - 2;
            // Only a strictly stronger peak displaces the one already kept.
            if (b >= thr && b >= a && b >= s && (!best_hit || b > int'(best_str)))
            begin
                offs      = want_sub ? parabola_offset(a, b, s) : 0;
                best_hit  = 1'b1;
                best_str  = b[STRENGTH_W-1:0];
                best_idx  = j[INDEX_W-1:0];
                best_sub  = SUBINDEX_W'(j * 256 + offs);
                best_grad = hist_grad[1];
            end
        end
        hist_val[0]   = hist_val[1];
        hist_val[1]   = v;
        hist_ok[0]    = hist_ok[1];
        hist_ok[1]    = ok;
        hist_score[0] = hist_score[1];
        hist_score[1] = s[STRENGTH_W-1:0];
        hist_grad[0]  = hist_grad[1];
        hist_grad[1]  = g[GRADIENT_W-1:0];
        prof_count    = prof_count + 1'b1;
    endfunction

    // Account for one accepted sample word and queue the report it closes.
    function automatic void accept_sample(profile_sample_t w);
        edge_report_t rep;
        if (prof_count >= MAX_SAMPLES)
            prof_overflow = 1'b1;
        else
            track_sample(w.value, w.ok);
        if (w.last)
        begin
            rep = '0;
            if (best_hit)
            begin
                rep.found = 1'b1;
                rep.idx   = best_idx;
                rep.sub   = best_sub;
                rep.str   = best_str;
                rep.grad  = best_grad;
            end
            rep.ovf = prof_overflow;
            pending_reports = {pending_reports, rep};
            clear_profile();
        end
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Sample driver: presents the backlog word by word, with random gaps while tx_idle is set.
    always @(posedge clk)
    begin : tx_driver
        profile_sample_t nxt;
        logic            offer;
        int unsigned     gap_now;
        offer   = tx_valid;
        gap_now = tx_gap;
        if (!rst_n)
        begin
            tx_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            if (tx_valid && smp.ready)
            begin
                accept_sample(tx_word);
                offer   = 1'b0;
                gap_now = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (!offer)
            begin
                if (gap_now > 0)
                    gap_now--;
                else if (sample_backlog.size() > 0)
                begin
                    nxt     = sample_backlog.pop_front();
                    tx_word <= nxt;
                    offer   = 1'b1;
                end
            end
            tx_valid <= offer;
            tx_gap   <= gap_now;
        end
    end

    // Report monitor: compares each accepted word with the oldest expectation.
    always @(posedge clk)
    begin : rx_monitor
        edge_report_t want;
        int unsigned  wait_now;
        wait_now = rx_wait;
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
            rx_wait  <= 0;
        end
        else
        begin
            if (res.valid && rx_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: report expected none actual found=%0d index=%0d",
                             $time, res.edge_found, res.edge_index);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("edge_found", want.found, res.edge_found);
                    check_field("edge_index", want.idx, res.edge_index);
                    check_field("edge_subindex", want.sub, res.edge_subindex);
                    check_field("edge_strength", want.str, res.edge_strength);
                    check_field("edge_gradient", $signed(want.grad), res.edge_gradient);
                    check_field("profile_overflow", want.ovf, res.profile_overflow);
                end
                wait_now = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (wait_now > 0)
                wait_now--;
            rx_ready <= !rx_hold && wait_now == 0;
            rx_wait  <= wait_now;
        end
    end

    // Long receiver hold-off, so that the job queue fills and the input stalls.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic push_sample(int v, logic ok, logic last);
        profile_sample_t w;
        w.value = v[SAMPLE_BITS-1:0];
        w.ok    = ok;
        w.last  = last;
        sample_backlog = {sample_backlog, w};
    endtask

    // Queue one profile: a level with steps and light noise, or pure noise.
    task automatic queue_profile(int len, logic noisy);
        int level;
        int v;
        level = $urandom_range(0, 65535);
        for (int k = 0; k < len; k++)
        begin
            if (noisy)
                v = $urandom_range(0, 65535);
            else
            begin
                case ($urandom_range(0, 11))
                    0:       level = (level < 32768) ? 65535 : 0;
                    1, 2:    level = level + int'($urandom_range(0, 12000)) - 6000;
                    default: ;
                endcase
                if (level < 0)
                    level = 0;
                if (level > 65535)
                    level = 65535;
                v = level + int'($urandom_range(0, 6)) - 3;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
            end
            push_sample(v, $urandom_range(0, 15) != 0, k == len - 1);
        end
    endtask

    // Register write; the local copy follows once the word is taken.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_POLARITY:  want_pol = val[1:0];
            REG_THRESHOLD: want_thr = val;
            REG_SUBPIXEL:  want_sub = val[0];
            default:       ;
        endcase
    endtask

    // Wait until every word is sent and every report is back, then let the back drain.
    task automatic settle();
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || tx_valid || pending_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_items;
        int len;
        int sel;
        clear_profile();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed profiles under the reset settings.
        // A single sample and a four-sample profile are too short to hold a peak and report no edge.
        push_sample(0, 1'b1, 1'b1);
        push_sample(65535, 1'b1, 1'b0);
        push_sample(0, 1'b1, 1'b0);
        push_sample(65535, 1'b1, 1'b0);
        push_sample(0, 1'b1, 1'b1);
        // Full-scale rise on the shortest profile that can hold an edge.
        push_sample(0, 1'b1, 1'b0);
        push_sample(0, 1'b1, 1'b0);
        push_sample(65535, 1'b1, 1'b0);
        push_sample(65535, 1'b1, 1'b0);
        push_sample(65535, 1'b1, 1'b1);
        // Ramp with a missing sample in the middle.
        for (int k = 0; k < 8; k++)
            push_sample(100 * (k + 1), k != 3, k == 7);
        // Full-scale fall with two equal peaks; the first one is kept.
        for (int k = 0; k < 6; k++)
            push_sample((k < 3) ? 65535 : 0, 1'b1, k == 5);
        settle();

        // Random profiles over a sweep of register settings and idling modes.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_RISING));
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_SUBPIXEL, 16'd0);
                end
                1:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_FALLING));
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_SUBPIXEL, 16'd1);
                end
                2:
                begin
                    write_reg(REG_POLARITY, 16'd3);
                    write_reg(REG_THRESHOLD, 16'd300);
                    write_reg(REG_SUBPIXEL, 16'd1);
                end
                3:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_ANY));
                    write_reg(REG_THRESHOLD, 16'hFFFF);
                    write_reg(REG_SUBPIXEL, 16'd1);
                end
                4:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_RISING));
                    write_reg(REG_THRESHOLD, 16'd1000);
                    write_reg(REG_SUBPIXEL, 16'd1);
                end
                5:
                begin
                    // Upper data bits must be ignored by the narrow registers.
                    write_reg(REG_POLARITY, 16'hFFFE);
                    write_reg(REG_THRESHOLD, 16'd5000);
                    write_reg(REG_SUBPIXEL, 16'hFFFE);
                end
                6:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_ANY));
                    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 4000)));
                    write_reg(REG_SUBPIXEL, CFG_DATA_W'($urandom_range(0, 1)));
                end
                default:
                begin
                    write_reg(REG_POLARITY, CFG_DATA_W'(POL_ANY));
                    write_reg(REG_THRESHOLD, 16'd0);
                    write_reg(REG_SUBPIXEL, 16'd1);
                    write_reg(REG_UNUSED, 16'hFFFF);
                end
            endcase
            tx_idle <= (ph % 4 == 0) || (ph % 4 == 1);
            rx_idle <= (ph % 4 == 0) || (ph % 4 == 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    len = $urandom_range(1, 4);
                else if (sel == 1)
                    len = $urandom_range(40, 90);
                else
                    len = $urandom_range(5, 24);
                queue_profile(len, sel == 2);
                phase_items += len;
            end
            settle();
        end

        // Many short profiles against a stalled receiver.
        write_reg(REG_POLARITY, CFG_DATA_W'(POL_ANY));
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_SUBPIXEL, 16'd1);
        tx_idle <= 1'b0;
        rx_idle <= 1'b0;
        hold_go <= 1'b1;
        for (int k = 0; k < 40; k++)
            queue_profile($urandom_range(5, 6), 1'b0);
        settle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
